@@ src/pfhs_pkg.sv @@
package pfhs_pkg;

  // Field widths of the transfer items
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 9;
  localparam int LVL_W     = 9;
  localparam int ERR_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_SPACE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POP_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_MODE = 2'd3;

  // Register reset values
  localparam int RST_INITIAL_LIMIT = 256;
  localparam int RST_WINDOW_SIZE   = 16;
  localparam int RST_POP_THRESHOLD = 8;

  typedef struct packed {
    logic              operation;
    logic [DATA_W-1:0] payload;
    logic              start_flag;
    logic              end_flag;
    logic              final_flag;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] popped_payload;
    logic              popped_start;
    logic              popped_end;
    logic              popped_final;
    logic [LVL_W-1:0]  space_avail;
    logic [LVL_W-1:0]  current_limit;
    logic              store_empty;
    logic              head_is_start;
    logic              window_full;
    logic              ready_to_pop;
    logic [ERR_W-1:0]  error_code;
  } out_item_t;

  // One stored word
  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic              start_flag;
    logic              end_flag;
    logic              final_flag;
  } word_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic  is_pop;
    logic  end_last;
    word_t word;
  } cmd_t;

endpackage

@@ src/packet_fifo_head_status_core.sv @@
// Channel   Direction  Handshake             Payload
// in_*      input      in_valid / in_stall   in_item_t: push or pop request
// out_*     output     out_valid / out_stall out_item_t: one result per request
// cfg_*     input      cfg_wr_en             cfg_index, cfg_wdata
//
// A request passes a front register and a two-entry queue before the back engine.
// The engine takes a push in its idle state; a pop also passes the head state
// when a word stays behind it, as the new head is read through the store's
// registered read port.
// Reset is synchronous, active low; the word store is not cleared.
// Either side may stall; the queue and the result register decouple them.
module packet_fifo_head_status_core #(
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pfhs_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pfhs_pkg::out_item_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [pfhs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfhs_pkg::CFG_W-1:0]     cfg_wdata
);
  import pfhs_pkg::*;

  logic f_push_valid;
  logic q_full;
  cmd_t f_cmd;
  logic q_valid;
  logic q_take;
  cmd_t q_cmd;

  // Accept and classify
  pfhs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .q_push_valid (f_push_valid),
    .q_full       (q_full),
    .q_push_cmd   (f_cmd)
  );

  // Decouple front from back
  pfhs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .full       (q_full),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_take   (q_take),
    .pop_cmd    (q_cmd)
  );

  // Execute against the store
  pfhs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

@@ src/pfhs_front.sv @@
module pfhs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfhs_pkg::in_item_t in_data,
  output logic              q_push_valid,
  input  logic              q_full,
  output pfhs_pkg::cmd_t    q_push_cmd
);
  import pfhs_pkg::*;

  logic f_valid_r;
  cmd_t f_cmd_r;
  cmd_t f_cmd_nxt;
  logic take;

  // Classify the incoming item
  always_comb begin
    f_cmd_nxt.is_pop   = (in_data.operation == OP_POP);
    f_cmd_nxt.end_last = in_data.end_flag && in_data.final_flag &&
                         (in_data.operation == OP_PUSH);
    if (in_data.operation == OP_POP) begin
      f_cmd_nxt.word = '0;
    end else begin
      f_cmd_nxt.word.payload    = in_data.payload;
      f_cmd_nxt.word.start_flag = in_data.start_flag;
      f_cmd_nxt.word.end_flag   = in_data.end_flag;
      f_cmd_nxt.word.final_flag = in_data.final_flag;
    end
  end

  // Hold the stage while the queue is full
  assign in_stall     = f_valid_r && q_full;
  assign take         = in_valid && !in_stall;
  assign q_push_valid = f_valid_r;
  assign q_push_cmd   = f_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      if (!f_valid_r || !q_full) begin
        f_valid_r <= in_valid;
      end
      if (take) begin
        f_cmd_r <= f_cmd_nxt;
      end
    end
  end

endmodule

@@ src/pfhs_queue.sv @@
module pfhs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           full,
  input  pfhs_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_take,
  output pfhs_pkg::cmd_t pop_cmd
);
  import pfhs_pkg::*;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = ent_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_take && pop_valid;

  function automatic logic [QPTR_W-1:0] qinc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        ent_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r        <= qinc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= qinc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ src/pfhs_back.sv @@
module pfhs_back #(
  parameter int DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_take,
  input  pfhs_pkg::cmd_t                  q_cmd,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pfhs_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [pfhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfhs_pkg::CFG_W-1:0]      cfg_wdata
);
  import pfhs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (OCC_W > LVL_W) ? OCC_W : LVL_W;

  typedef enum logic {ST_IDLE, ST_HEAD} state_t;

  typedef struct packed {
    logic head_start;
    logic window_full;
    logic pop_armed;
  } head_stat_t;

  // Word store
  word_t mem [DEPTH];
  word_t rd_data_r;
  logic [PTR_W-1:0] rd_addr;
  logic mem_we;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [OCC_W-1:0]  elc_r, elc_nxt;
  logic [LIM_W-1:0]  limit_r, limit_nxt;
  logic [LIM_W-1:0]  space_r, space_nxt;
  logic [CFG_W-1:0]  win_r, win_nxt;
  logic [CFG_W-1:0]  thr_r, thr_nxt;
  logic              ovf_r, ovf_nxt;
  head_stat_t        stat_r, stat_nxt;
  word_t             head_word_r, head_word_nxt;
  word_t             popped_r, popped_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              out_free;
  logic              load_out;
  word_t             res_word;
  logic [ERR_W-1:0]  res_err;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [LIM_W-1:0] sat_sub(input logic [LIM_W-1:0] a,
                                               input logic [LIM_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Head status after an operation; the pop flag holds when the store is empty
  function automatic head_stat_t head_status(input logic [OCC_W-1:0] occ,
                                             input logic             start,
                                             input logic [OCC_W-1:0] elc,
                                             input logic [CFG_W-1:0] win,
                                             input logic [CFG_W-1:0] thr,
                                             input logic             pr_prev);
    head_stat_t s;
    logic       met_win;
    logic       met_thr;
    met_win = (LIM_W'(occ) >= LIM_W'(win)) || (elc != '0);
    met_thr = (LIM_W'(occ) >= LIM_W'(thr)) || (elc != '0);
    if (occ == '0) begin
      s.head_start  = 1'b0;
      s.window_full = 1'b0;
      s.pop_armed   = pr_prev;
    end else if (start) begin
      s.head_start  = 1'b1;
      s.window_full = met_win;
      s.pop_armed   = 1'b0;
    end else begin
      s.head_start  = 1'b0;
      s.window_full = 1'b0;
      s.pop_armed   = met_thr;
    end
    return s;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign rd_addr   = ptr_inc(rp_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Store writes and registered read of the word behind the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= q_cmd.word;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Execute commands
  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    occ_nxt       = occ_r;
    elc_nxt       = elc_r;
    limit_nxt     = limit_r;
    space_nxt     = space_r;
    win_nxt       = win_r;
    thr_nxt       = thr_r;
    ovf_nxt       = ovf_r;
    stat_nxt      = stat_r;
    head_word_nxt = head_word_r;
    popped_nxt    = popped_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    q_take        = 1'b0;
    load_out      = 1'b0;
    res_word      = '0;
    res_err       = ERR_NONE;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_take = 1'b1;
          if (!q_cmd.is_pop) begin
            load_out = 1'b1;
            if (space_r == '0 || occ_r >= OCC_W'(DEPTH)) begin
              res_err = ERR_NO_SPACE;
            end else begin
              mem_we  = 1'b1;
              wp_nxt  = ptr_inc(wp_r);
              occ_nxt = occ_r + 1'b1;
              if (q_cmd.end_last) begin
                elc_nxt = elc_r + 1'b1;
              end
              if (ovf_r) begin
                if (LIM_W'(occ_nxt) > limit_r) begin
                  limit_nxt = LIM_W'(occ_nxt);
                end
              end else begin
                space_nxt = sat_sub(limit_r, LIM_W'(occ_nxt));
              end
              if (occ_r == '0) begin
                head_word_nxt = q_cmd.word;
              end
              stat_nxt = head_status(occ_nxt,
                                     (occ_r == '0) ? q_cmd.word.start_flag
                                                   : stat_r.head_start,
                                     elc_nxt, win_r, thr_r, stat_r.pop_armed);
            end
          end else begin
            if (occ_r == '0) begin
              load_out = 1'b1;
              res_err  = ERR_EMPTY;
            end else begin
              rp_nxt    = ptr_inc(rp_r);
              occ_nxt   = occ_r - 1'b1;
              if (head_word_r.end_flag && head_word_r.final_flag && elc_r != '0) begin
                elc_nxt = elc_r - 1'b1;
              end
              space_nxt = sat_sub(limit_r, LIM_W'(occ_nxt));
              if (occ_nxt == '0) begin
                load_out = 1'b1;
                res_word = head_word_r;
                stat_nxt = head_status(occ_nxt, 1'b0, elc_nxt, win_r, thr_r,
                                       stat_r.pop_armed);
              end else begin
                // fetch the new head on the next cycle
                popped_nxt = head_word_r;
                state_nxt  = ST_HEAD;
              end
            end
          end
        end
      end
      ST_HEAD: begin
        head_word_nxt = rd_data_r;
        stat_nxt      = head_status(occ_r, rd_data_r.start_flag, elc_r, win_r, thr_r,
                                    stat_r.pop_armed);
        res_word      = popped_r;
        load_out      = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load the result register
    if (load_out) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.popped_payload  = res_word.payload;
      out_data_nxt.popped_start    = res_word.start_flag;
      out_data_nxt.popped_end      = res_word.end_flag;
      out_data_nxt.popped_final    = res_word.final_flag;
      out_data_nxt.space_avail     = space_nxt[LVL_W-1:0];
      out_data_nxt.current_limit   = limit_nxt[LVL_W-1:0];
      out_data_nxt.store_empty     = (occ_nxt == '0);
      out_data_nxt.head_is_start   = stat_nxt.head_start;
      out_data_nxt.window_full     = stat_nxt.window_full;
      out_data_nxt.ready_to_pop    = stat_nxt.pop_armed;
      out_data_nxt.error_code      = res_err;
    end

    // Register writes
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_INITIAL_LIMIT: begin
          limit_nxt = LIM_W'(cfg_wdata);
          space_nxt = LIM_W'(cfg_wdata);
        end
        REG_WINDOW_SIZE:   win_nxt = cfg_wdata;
        REG_POP_THRESHOLD: thr_nxt = cfg_wdata;
        REG_OVERFLOW_MODE: ovf_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      occ_r       <= '0;
      elc_r       <= '0;
      limit_r     <= LIM_W'(RST_INITIAL_LIMIT);
      space_r     <= LIM_W'(RST_INITIAL_LIMIT);
      win_r       <= CFG_W'(RST_WINDOW_SIZE);
      thr_r       <= CFG_W'(RST_POP_THRESHOLD);
      ovf_r       <= 1'b0;
      stat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      occ_r       <= occ_nxt;
      elc_r       <= elc_nxt;
      limit_r     <= limit_nxt;
      space_r     <= space_nxt;
      win_r       <= win_nxt;
      thr_r       <= thr_nxt;
      ovf_r       <= ovf_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    head_word_r <= head_word_nxt;
    popped_r    <= popped_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above store depth");

  a_elc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elc_r <= occ_r)
    else $error("end-and-last count above occupancy");

  a_head_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HEAD |=> state_r == ST_IDLE)
    else $error("head fetch lasted more than one cycle");

  a_head_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HEAD |-> !out_valid_r && occ_r != '0)
    else $error("head fetch with busy result register or empty store");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> !stat_r.head_start && !stat_r.window_full)
    else $error("head status set on empty store");

endmodule

@@ dv/packet_fifo_head_status_core_test.sv @@
`timescale 1ns / 100ps

module packet_fifo_head_status_core_test;
  import pfhs_pkg::*;

  localparam int STORE_DEPTH = 256;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  packet_fifo_head_status_core #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the packet FIFO: stored words, pointers, levels and head flags
  word_t            word_mem [STORE_DEPTH];
  logic [7:0]       head_ptr       = '0;
  logic [7:0]       tail_ptr       = '0;
  int               fill           = 0;
  int               end_last_words = 0;
  logic [CFG_W-1:0] window_need    = CFG_W'(RST_WINDOW_SIZE);
  logic [CFG_W-1:0] pop_need       = CFG_W'(RST_POP_THRESHOLD);
  logic             grow_mode      = 1'b0;
  logic [LVL_W-1:0] limit_lvl      = LVL_W'(RST_INITIAL_LIMIT);
  logic [LVL_W-1:0] space_lvl      = LVL_W'(RST_INITIAL_LIMIT);
  logic             head_start     = 1'b0;
  logic             window_ok      = 1'b0;
  logic             pop_ok         = 1'b0;

  out_item_t result_q [$];

  int send_gap_pct   = 31;
  int recv_stall_pct = 63;
  int pkt_words_left = 0;
  int n_requests     = 0;
  int n_checked      = 0;
  int n_refused      = 0;
  int n_full_refused = 0;
  int n_empty_pops   = 0;
  int n_mismatches   = 0;

  // Limit minus fill, clamped at zero
  function automatic logic [LVL_W-1:0] space_left();
    return (int'(limit_lvl) > fill) ? LVL_W'(int'(limit_lvl) - fill) : '0;
  endfunction

  // Recompute head status after a successful push or pop
  function automatic void update_head_flags();
    if (fill == 0) begin
      head_start = 1'b0;
      window_ok  = 1'b0;
    end else begin
      head_start = word_mem[head_ptr].start_flag;
      if (head_start) begin
        pop_ok    = 1'b0;
        window_ok = (fill >= int'(window_need)) || (end_last_words != 0);
      end else begin
        window_ok = 1'b0;
        pop_ok    = (fill >= int'(pop_need)) || (end_last_words != 0);
      end
    end
  endfunction

  // Apply one request to the mirror and return the result it must produce
  function automatic out_item_t fifo_step(in_item_t req);
    out_item_t res;
    word_t     w;
    res = '0;
    if (req.operation == OP_PUSH) begin
      if (space_lvl == 0 || fill >= STORE_DEPTH) begin
        res.error_code = ERR_NO_SPACE;
      end else begin
        w.payload    = req.payload;
        w.start_flag = req.start_flag;
        w.end_flag   = req.end_flag;
        w.final_flag = req.final_flag;
        word_mem[tail_ptr] = w;
        tail_ptr++;
        fill++;
        if (w.end_flag && w.final_flag) end_last_words++;
        if (grow_mode) begin
          if (fill > int'(limit_lvl)) limit_lvl = LVL_W'(fill);
        end else begin
          space_lvl = space_left();
        end
        update_head_flags();
      end
    end else begin
      if (fill == 0) begin
        res.error_code = ERR_EMPTY;
      end else begin
        w = word_mem[head_ptr];
        head_ptr++;
        fill--;
        if (w.end_flag && w.final_flag && end_last_words != 0) end_last_words--;
        space_lvl = space_left();
        update_head_flags();
        res.popped_payload = w.payload;
        res.popped_start   = w.start_flag;
        res.popped_end     = w.end_flag;
        res.popped_final   = w.final_flag;
      end
    end
    res.space_avail     = space_lvl;
    res.current_limit   = limit_lvl;
    res.store_empty     = (fill == 0);
    res.head_is_start   = head_start;
    res.window_full     = window_ok;
    res.ready_to_pop    = pop_ok;
    return res;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_mismatches++;
    end
  endfunction

  // Check each result transfer against the oldest pending expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result transfer with no request pending");
        n_mismatches++;
      end else begin
        want = result_q.pop_front();
        check_field("popped_payload", want.popped_payload, out_data.popped_payload);
        check_field("popped_start", DATA_W'(want.popped_start),
                    DATA_W'(out_data.popped_start));
        check_field("popped_end", DATA_W'(want.popped_end), DATA_W'(out_data.popped_end));
        check_field("popped_final", DATA_W'(want.popped_final),
                    DATA_W'(out_data.popped_final));
        check_field("space_avail", DATA_W'(want.space_avail),
                    DATA_W'(out_data.space_avail));
        check_field("current_limit", DATA_W'(want.current_limit),
                    DATA_W'(out_data.current_limit));
        check_field("store_empty", DATA_W'(want.store_empty),
                    DATA_W'(out_data.store_empty));
        check_field("head_is_start", DATA_W'(want.head_is_start),
                    DATA_W'(out_data.head_is_start));
        check_field("window_full", DATA_W'(want.window_full),
                    DATA_W'(out_data.window_full));
        check_field("ready_to_pop", DATA_W'(want.ready_to_pop),
                    DATA_W'(out_data.ready_to_pop));
        check_field("error_code", DATA_W'(want.error_code), DATA_W'(out_data.error_code));
        n_checked++;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one request, with random gaps ahead of it, and hold it until transfer
  task automatic send_request(in_item_t req);
    out_item_t res;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = fifo_step(req);
    result_q.insert(result_q.size(), res);
    n_requests++;
    if (res.error_code == ERR_NO_SPACE) begin
      n_refused++;
      if (fill >= STORE_DEPTH) n_full_refused++;
    end
    if (res.error_code == ERR_EMPTY) n_empty_pops++;
  endtask

  task automatic push_word(logic [DATA_W-1:0] data, logic sop, logic eop, logic last);
    in_item_t req;
    req.operation  = OP_PUSH;
    req.payload    = data;
    req.start_flag = sop;
    req.end_flag   = eop;
    req.final_flag = last;
    send_request(req);
  endtask

  task automatic pop_word();
    in_item_t req;
    req            = '0;
    req.operation  = OP_POP;
    req.payload    = $urandom;
    req.start_flag = 1'($urandom_range(0, 1));
    req.end_flag   = 1'($urandom_range(0, 1));
    req.final_flag = 1'($urandom_range(0, 1));
    send_request(req);
  endtask

  // Hold off the sender until every pending result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  // Drive one register write; the caller drops the write enable
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    case (idx)
      REG_INITIAL_LIMIT: begin
        limit_lvl   = LVL_W'(val);
        space_lvl   = LVL_W'(val);
      end
      REG_WINDOW_SIZE:   window_need = CFG_W'(val);
      REG_POP_THRESHOLD: pop_need    = CFG_W'(val);
      REG_OVERFLOW_MODE: grow_mode   = val[0];
      default: ;
    endcase
  endtask

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, int val);
    wait_for_results();
    write_reg(idx, val);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(int lim, int win, int thr, int grow);
    wait_for_results();
    write_reg(REG_INITIAL_LIMIT, lim);
    write_reg(REG_WINDOW_SIZE, win);
    write_reg(REG_POP_THRESHOLD, thr);
    write_reg(REG_OVERFLOW_MODE, grow);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed packets with random content, some stray flags, random pops
  task automatic run_random(int n_items, int push_pct);
    in_item_t req;
    for (int i = 0; i < n_items; i++) begin
      req.payload = $urandom;
      if ($urandom_range(0, 99) < push_pct) begin
        req.operation = OP_PUSH;
        if ($urandom_range(0, 9) < 8) begin
          req.start_flag = (pkt_words_left == 0);
          if (pkt_words_left == 0) begin
            pkt_words_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                         : $urandom_range(1, 12);
          end
          req.end_flag   = (pkt_words_left == 1);
          req.final_flag = req.end_flag && ($urandom_range(0, 3) != 0);
          pkt_words_left--;
        end else begin
          {req.start_flag, req.end_flag, req.final_flag} = 3'($urandom_range(0, 7));
        end
      end else begin
        req.operation = OP_POP;
        {req.start_flag, req.end_flag, req.final_flag} = 3'($urandom_range(0, 7));
      end
      send_request(req);
      // Let the block go fully idle once per phase
      if (i == n_items / 2) wait_for_results();
    end
  endtask

  task automatic test_push_pop_basics();
    pop_word();
    push_word('0, 1'b0, 1'b0, 1'b0);
    push_word('1, 1'b1, 1'b1, 1'b1);
    push_word(32'h8000_0001, 1'b0, 1'b1, 1'b0);
    pop_word();
    pop_word();
    pop_word();
  endtask

  task automatic test_limit_refusal();
    write_one(REG_INITIAL_LIMIT, 0);
    push_word(32'h1234_5678, 1'b1, 1'b0, 1'b0);
    pop_word();
    write_one(REG_INITIAL_LIMIT, 2);
    push_word(32'hA5A5_A5A5, 1'b1, 1'b0, 1'b0);
    push_word(32'h5A5A_5A5A, 1'b0, 1'b1, 1'b1);
    push_word(32'hDEAD_BEEF, 1'b0, 1'b0, 1'b1);
  endtask

  // Grow the limit in overflow mode, then leave it below the fill level
  task automatic test_overflow_growth();
    write_one(REG_INITIAL_LIMIT, 1);
    write_one(REG_OVERFLOW_MODE, 1);
    push_word(32'h0F0F_0F0F, 1'b1, 1'b0, 1'b0);
    push_word(32'hF0F0_F0F0, 1'b0, 1'b0, 1'b1);
    write_one(REG_OVERFLOW_MODE, 0);
    pop_word();
    write_one(REG_INITIAL_LIMIT, 1);
    push_word(32'h0000_FFFF, 1'b0, 1'b1, 1'b0);
    push_word(32'hFFFF_0000, 1'b1, 1'b1, 1'b1);
    pop_word();
  endtask

  task automatic test_zero_thresholds();
    write_one(REG_WINDOW_SIZE, 0);
    write_one(REG_POP_THRESHOLD, 0);
    pop_word();
    pop_word();
    pop_word();
    pop_word();
  endtask

  task automatic test_traffic_default();
    configure(RST_INITIAL_LIMIT, RST_WINDOW_SIZE, RST_POP_THRESHOLD, 0);
    run_random(460, 55);
  endtask

  task automatic test_traffic_overflow_fill();
    configure(40, 1, 256, 1);
    send_gap_pct   = 63;
    recv_stall_pct = 31;
    run_random(460, 75);
  endtask

  task automatic test_traffic_drain();
    configure(256, 256, 1, 0);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(460, 30);
  endtask

  task automatic test_traffic_tight_limit();
    configure(7, 3, 2, 0);
    run_random(460, 40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_push_pop_basics();
    test_limit_refusal();
    test_overflow_growth();
    test_zero_thresholds();
    test_traffic_default();
    test_traffic_overflow_fill();
    test_traffic_drain();
    test_traffic_tight_limit();
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests: %0d pushes refused (%0d on a full store), %0d empty pops.",
             n_requests, n_refused, n_full_refused, n_empty_pops);
    $display("Checked %0d results with %0d field mismatches.", n_checked, n_mismatches);
    if (n_mismatches == 0) begin
      $display("** packet_fifo_head_status_core: PASSED **");
    end else begin
      $display("** packet_fifo_head_status_core: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", result_q.size());
    $display("** packet_fifo_head_status_core: FAILED **");
    $finish;
  end

endmodule
